FILE: rtl/conv3x3_same_pad_multichannel_assert.svh
// Assertion macros for the 3x3 convolution block.
`ifndef CONV3X3_SAME_PAD_MULTICHANNEL_ASSERT_SVH
`define CONV3X3_SAME_PAD_MULTICHANNEL_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define C3_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define C3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/c3sp_pkg.sv
// Package with fixed widths, operation codes and saturation helpers.
package c3sp_pkg;
  localparam int unsigned PixW  = 16;
  localparam int unsigned CoefW = 32;
  localparam int unsigned AccW  = 40;
  localparam int unsigned PosW  = 5;
  localparam int unsigned ChW   = 3;
  localparam int unsigned IdxW  = 6;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpPixel = 1'b1;

  typedef struct packed {
    logic [ChW-1:0]  channel;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            last;
  } res_tag_t;

  function automatic logic signed [PixW-1:0] sat16(input logic signed [CoefW-1:0] v);
    logic signed [PixW-1:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[PixW-1:0];
    return r;
  endfunction

  function automatic logic signed [CoefW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [CoefW-1:0] r;
    if (v > 40'sh007fffffff) r = 32'sh7fffffff;
    else if (v < -40'sh0080000000) r = 32'sh80000000;
    else r = v[CoefW-1:0];
    return r;
  endfunction
endpackage

FILE: rtl/c3sp_if.sv
// Valid/ready channel interfaces for input items and results.
interface c3sp_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [c3sp_pkg::IdxW-1:0] coef_index;
  logic signed [c3sp_pkg::CoefW-1:0] coef_value;
  logic signed [c3sp_pkg::PixW-1:0] pixel;
  modport source (output valid, operation, coef_index, coef_value, pixel, input ready);
  modport sink (input valid, operation, coef_index, coef_value, pixel, output ready);
endinterface

interface c3sp_out_if;
  logic valid;
  logic ready;
  logic [c3sp_pkg::ChW-1:0] channel;
  logic [c3sp_pkg::PosW-1:0] out_row;
  logic [c3sp_pkg::PosW-1:0] out_col;
  logic signed [c3sp_pkg::CoefW-1:0] value;
  logic last;
  modport source (output valid, channel, out_row, out_col, value, last, input ready);
  modport sink (input valid, channel, out_row, out_col, value, last, output ready);
endinterface

FILE: rtl/c3sp_mac.sv
// Nine-tap multiply-accumulate with a registered product stage and saturation.
module c3sp_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               tap_vld_i,
  input  logic signed [c3sp_pkg::PixW-1:0]   pix_i,
  input  logic signed [c3sp_pkg::PixW-1:0]   wgt_i,
  input  logic                               bias_vld_i,
  input  logic signed [c3sp_pkg::CoefW-1:0]  bias_i,
  output logic signed [c3sp_pkg::CoefW-1:0]  sum_o
);
  logic signed [c3sp_pkg::CoefW-1:0] prod_q, prod_d;
  logic prod_vld_q;
  logic signed [c3sp_pkg::AccW-1:0] acc_q, acc_d, acc_base;

  assign prod_d = pix_i * wgt_i;

  always_comb begin
    acc_base = start_i ? '0 : acc_q;
    acc_d = acc_base;
    if (prod_vld_q) acc_d = acc_d + c3sp_pkg::AccW'(prod_q);
    if (bias_vld_i) acc_d = acc_d + c3sp_pkg::AccW'(bias_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= tap_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign sum_o = c3sp_pkg::sat32(acc_q);
endmodule

FILE: rtl/conv3x3_same_pad_multichannel.sv
// Top level of the streaming 3x3 same-padded convolution block.
// A load transaction writes a weight or bias entry. A pixel transaction writes
// the pixel to a three-row line memory, then for each completed window position
// and each channel runs nine taps through one shared multiplier, one tap per
// cycle, reading the line and weight memories through registered reads and
// adding the bias at the end. An interior pixel completes one position, a
// right-column or bottom-row pixel two and the bottom-right corner four. A
// pixel in the first row or first column completes no window. A result that is
// held off stalls the next result in its sum state until it is taken. The
// line memory holds 3 x IMG_DIM entries; taps outside the image are replaced by
// zero, so no clearing pass is needed. A result register lets the next
// computation, and the next transaction, start while a result waits.
module conv3x3_same_pad_multichannel #(
  parameter int unsigned IMG_DIM  = 28,
  parameter int unsigned CHANNELS = 5
) (
  input logic clk_i,
  input logic rst_ni,
  c3sp_in_if.sink    in_i,
  c3sp_out_if.source out_o
);
  localparam int unsigned NW = CHANNELS * 9;
  localparam int unsigned NC = CHANNELS * 10;
  localparam int unsigned LD = 3 * IMG_DIM;
  localparam int unsigned LAW = $clog2(LD);
  localparam int unsigned WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned BAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW = $clog2(IMG_DIM);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_TAP = 6'b000010, S_DRAIN = 6'b000100,
    S_BIAS = 6'b001000, S_SUM = 6'b010000, S_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic signed [c3sp_pkg::PixW-1:0] line_mem [LD];
  logic signed [c3sp_pkg::PixW-1:0] wgt_mem [NW];
  logic signed [c3sp_pkg::CoefW-1:0] bias_mem [CHANNELS];
  logic signed [c3sp_pkg::PixW-1:0] line_rd_q, wgt_rd_q;
  logic signed [c3sp_pkg::CoefW-1:0] bias_rd_q;

  logic [PW-1:0] row_q, row_d, col_q, col_d;   // raster position of next pixel
  logic [PW-1:0] pi_q, pj_q;                    // pixel being processed
  logic [1:0] pm_q;                             // line slot of the pixel being processed
  logic [1:0] pr_q, pr_d, pc_q, pc_d;           // position index within the set
  logic [BAW-1:0] ch_q, ch_d;
  logic [3:0] tap_q, tap_d;
  logic tap_rd_q, tap_in_q;
  logic [1:0] nr, nc;
  logic [PW:0] orow, ocol;
  logic signed [PW+1:0] sr, sc;
  logic in_img;
  logic [1:0] rmod;
  logic [LAW-1:0] laddr, waddr_line;
  logic [WAW-1:0] wra;
  logic signed [c3sp_pkg::CoefW-1:0] sum;
  logic res_vld_q;
  logic signed [c3sp_pkg::CoefW-1:0] res_val_q;
  c3sp_pkg::res_tag_t res_tag_q, tag_d;
  logic in_acc, out_acc, mac_start, bias_vld, last_pos, last_ch;
  logic [1:0] row_mod_q, row_mod_d;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // Window position count for the pixel being processed.
  assign nr = (pi_q == '0) ? 2'd0 : ((pi_q == PW'(IMG_DIM - 1)) ? 2'd2 : 2'd1);
  assign nc = (pj_q == '0) ? 2'd0 : ((pj_q == PW'(IMG_DIM - 1)) ? 2'd2 : 2'd1);
  assign orow = (pr_q == 2'd0) ? ({1'b0, pi_q} - 1'b1) : {1'b0, pi_q};
  assign ocol = (pc_q == 2'd0) ? ({1'b0, pj_q} - 1'b1) : {1'b0, pj_q};
  assign last_pos = (pr_q == nr - 2'd1) && (pc_q == nc - 2'd1);
  assign last_ch = (ch_q == BAW'(CHANNELS - 1));

  // Tap address for the current tap.
  always_comb begin
    sr = $signed({1'b0, orow}) - $signed((PW+2)'(1)) + $signed({{PW{1'b0}}, tap_q >= 4'd6, 1'b0})
       + $signed({{(PW+1){1'b0}}, tap_q >= 4'd3 && tap_q < 4'd6});
    sc = $signed({1'b0, ocol}) - $signed((PW+2)'(1))
       + $signed((PW+2)'((tap_q == 4'd1 || tap_q == 4'd4 || tap_q == 4'd7) ? 1 :
                         (tap_q == 4'd2 || tap_q == 4'd5 || tap_q == 4'd8) ? 2 : 0));
    in_img = (sr >= 0) && (sr < $signed((PW+2)'(IMG_DIM)))
          && (sc >= 0) && (sc < $signed((PW+2)'(IMG_DIM)));
    // Row slot: current pixel row maps to its own slot, earlier rows backwards.
    unique case (2'(pi_q - PW'(sr)))
      2'd0:    rmod = pm_q;
      2'd1:    rmod = (pm_q == 2'd0) ? 2'd2 : pm_q - 2'd1;
      default: rmod = (pm_q == 2'd2) ? 2'd0 : pm_q + 2'd1;
    endcase
    laddr = LAW'(rmod * IMG_DIM + 32'(sc[PW-1:0]));
    wra = WAW'(ch_q * 9 + 32'(tap_q));
    waddr_line = LAW'(row_mod_q * IMG_DIM + 32'(col_q));
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.operation == c3sp_pkg::OpPixel) line_mem[waddr_line] <= in_i.pixel;
    if (in_acc && in_i.operation == c3sp_pkg::OpLoad && in_i.coef_index < c3sp_pkg::IdxW'(NW))
      wgt_mem[WAW'(in_i.coef_index)] <= c3sp_pkg::sat16(in_i.coef_value);
    if (in_acc && in_i.operation == c3sp_pkg::OpLoad && in_i.coef_index >= c3sp_pkg::IdxW'(NW)
        && in_i.coef_index < c3sp_pkg::IdxW'(NC))
      bias_mem[BAW'(in_i.coef_index - c3sp_pkg::IdxW'(NW))] <= in_i.coef_value;
    line_rd_q <= line_mem[laddr];
    wgt_rd_q  <= wgt_mem[wra];
    bias_rd_q <= bias_mem[ch_q];
    tap_in_q  <= in_img;
  end

  c3sp_mac u_mac (
    .clk_i, .rst_ni,
    .start_i(mac_start),
    .tap_vld_i(tap_rd_q),
    .pix_i(tap_in_q ? line_rd_q : '0),
    .wgt_i(wgt_rd_q),
    .bias_vld_i(bias_vld),
    .bias_i(bias_rd_q),
    .sum_o(sum)
  );

  assign mac_start = (state_q == S_TAP) && (tap_q == 4'd0);
  assign bias_vld = (state_q == S_BIAS);
  assign tag_d = '{channel: c3sp_pkg::ChW'(ch_q), out_row: c3sp_pkg::PosW'(orow),
                   out_col: c3sp_pkg::PosW'(ocol), last: last_pos && last_ch};

  always_comb begin
    state_d = state_q; row_d = row_q; col_d = col_q; row_mod_d = row_mod_q;
    pr_d = pr_q; pc_d = pc_q; ch_d = ch_q; tap_d = tap_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_i.operation == c3sp_pkg::OpPixel) begin
        pr_d = 2'd0; pc_d = 2'd0; ch_d = '0; tap_d = '0;
        if (row_q != '0 && col_q != '0) state_d = S_TAP;
        else if (row_q != '0 && col_q == PW'(IMG_DIM - 1)) state_d = S_TAP;
        if (col_q == PW'(IMG_DIM - 1)) begin
          col_d = '0;
          row_mod_d = (row_mod_q == 2'd2) ? 2'd0 : row_mod_q + 2'd1;
          row_d = (row_q == PW'(IMG_DIM - 1)) ? '0 : row_q + 1'b1;
          if (row_q == PW'(IMG_DIM - 1)) row_mod_d = 2'd0;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_TAP: begin
        tap_d = tap_q + 4'd1;
        if (tap_q == 4'd8) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_BIAS;
      S_BIAS:  state_d = S_SUM;
      S_SUM:   if (!res_vld_q || out_acc) begin
        tap_d = '0;
        state_d = S_TAP;
        if (!last_ch) ch_d = ch_q + 1'b1;
        else begin
          ch_d = '0;
          if (pc_q != nc - 2'd1) pc_d = pc_q + 2'd1;
          else if (pr_q != nr - 2'd1) begin pc_d = 2'd0; pr_d = pr_q + 2'd1; end
          else state_d = S_OUT;
        end
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; row_q <= '0; col_q <= '0; row_mod_q <= '0;
      pr_q <= '0; pc_q <= '0; ch_q <= '0; tap_q <= '0; tap_rd_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d; row_q <= row_d; col_q <= col_d; row_mod_q <= row_mod_d;
      pr_q <= pr_d; pc_q <= pc_d; ch_q <= ch_d; tap_q <= tap_d;
      tap_rd_q <= (state_q == S_TAP);
      if (state_q == S_SUM && (!res_vld_q || out_acc)) res_vld_q <= 1'b1;
      else if (out_acc) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin pi_q <= row_q; pj_q <= col_q; pm_q <= row_mod_q; end
    if (state_q == S_SUM && (!res_vld_q || out_acc)) begin
      res_val_q <= sum;
      res_tag_q <= tag_d;
    end
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.channel = res_tag_q.channel;
  assign out_o.out_row = res_tag_q.out_row;
  assign out_o.out_col = res_tag_q.out_col;
  assign out_o.value   = res_val_q;
  assign out_o.last    = res_tag_q.last;

  `include "conv3x3_same_pad_multichannel_assert.svh"
  `C3_ASSERT_IMPL(a_busy_no_ready, clk_i, rst_ni, state_q != S_IDLE, !in_i.ready)
  `C3_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid)
  `C3_ASSERT_IMPL(a_col_range, clk_i, rst_ni, 1'b1, col_q < PW'(IMG_DIM))
endmodule
